FILE: sv/csd_pkg.sv
package csd_pkg;

   localparam int unsigned MaxSizeW = 17;
   localparam int unsigned LenW     = 32;
   localparam int unsigned QDepth   = 4;
   localparam int unsigned QAddrW   = $clog2(QDepth);
   localparam int unsigned QCountW  = $clog2(QDepth + 1);

   // prefix lead bytes
   localparam logic [7:0] PfxLen16 = 8'd253;
   localparam logic [7:0] PfxLen32 = 8'd254;

   // rsp status codes
   localparam logic [1:0] StatChar = 2'd0;
   localparam logic [1:0] StatDone = 2'd1;
   localparam logic [1:0] StatErr  = 2'd2;

   typedef enum logic [1:0] {
      END_NONE,
      END_OK,
      END_ERR
   } end_type;

   // what one request leaves for the back end
   typedef struct packed {
      logic            has_char;
      logic [7:0]      ch;
      end_type         fin;
      logic [LenW-1:0] len;
      logic            trunc;
   } rec_type;

endpackage

FILE: sv/csd_front.sv
module csd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              acc,
   input  logic [7:0]                        in_byte,
   input  logic                              eob,
   input  logic [csd_pkg::MaxSizeW-1:0]      max_size,
   output logic                              push,
   output csd_pkg::rec_type                  rec
);

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [3:0]                   left_ff, left_in;
   logic [2:0]                   idx_ff, idx_in;
   logic [csd_pkg::LenW-1:0]     len_ff, len_in;
   logic [csd_pkg::LenW-1:0]     pos_ff, pos_in;

   logic [csd_pkg::MaxSizeW-1:0] keep;
   logic [csd_pkg::LenW-1:0]     keep_w;
   logic [csd_pkg::LenW-1:0]     acc_v;
   logic [csd_pkg::LenW-1:0]     pos_v;
   logic [3:0]                   left_v;

   assign keep   = (max_size == '0) ? '0 : max_size - 1'b1;
   assign keep_w = {{(csd_pkg::LenW - csd_pkg::MaxSizeW){1'b0}}, keep};

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      rec.has_char = 1'b0;
      rec.ch       = in_byte;
      rec.fin      = csd_pkg::END_NONE;
      rec.len      = '0;
      rec.trunc    = 1'b0;
      acc_v        = '0;
      pos_v        = pos_ff + 1'b1;
      left_v       = (left_ff == 4'd0) ? 4'd0 : left_ff - 4'd1;
      if (acc) begin
         case (phase_ff)
            PH_LENGTH: begin
               acc_v = len_ff;
               if (!idx_ff[2]) begin
                  acc_v = len_ff | ({24'b0, in_byte} << {idx_ff[1:0], 3'b000});
               end
               idx_in  = idx_ff + 3'd1;
               left_in = left_v;
               len_in  = acc_v;
               if (left_v == 4'd0) begin
                  if (acc_v == '0) begin
                     rec.fin = csd_pkg::END_OK;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     pos_in   = '0;
                     if (eob) begin
                        rec.fin = csd_pkg::END_ERR;
                     end
                  end
               end else if (eob) begin
                  rec.fin = csd_pkg::END_ERR;
               end
            end
            PH_PAYLOAD: begin
               rec.has_char = (pos_ff < keep_w);
               pos_in       = pos_v;
               if (pos_v >= len_ff) begin
                  rec.fin   = csd_pkg::END_OK;
                  rec.len   = len_ff;
                  rec.trunc = (len_ff > keep_w);
               end else if (eob) begin
                  rec.fin = csd_pkg::END_ERR;
               end
            end
            default: begin
               left_in = 4'd0;
               idx_in  = 3'd0;
               pos_in  = '0;
               if (in_byte < csd_pkg::PfxLen16) begin
                  len_in = {24'b0, in_byte};
                  if (in_byte == 8'd0) begin
                     rec.fin = csd_pkg::END_OK;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     if (eob) begin
                        rec.fin = csd_pkg::END_ERR;
                     end
                  end
               end else begin
                  len_in   = '0;
                  phase_in = PH_LENGTH;
                  left_in  = (in_byte == csd_pkg::PfxLen16) ? 4'd2 :
                             (in_byte == csd_pkg::PfxLen32) ? 4'd4 : 4'd8;
                  if (eob) begin
                     rec.fin = csd_pkg::END_ERR;
                  end
               end
            end
         endcase
         // any frame end restarts prefix parsing
         if (rec.fin != csd_pkg::END_NONE) begin
            phase_in = PH_PREFIX;
            left_in  = 4'd0;
            idx_in   = 3'd0;
            len_in   = '0;
            pos_in   = '0;
         end
      end
   end

   assign push = acc && (rec.has_char || rec.fin != csd_pkg::END_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         left_ff  <= 4'd0;
         idx_ff   <= 3'd0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: sv/csd_queue.sv
module csd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csd_pkg::rec_type  push_rec,
   input  logic              pop,
   output csd_pkg::rec_type  head,
   output logic              empty,
   output logic              full
);

   csd_pkg::rec_type             mem_ff [csd_pkg::QDepth];
   logic [csd_pkg::QAddrW-1:0]   wr_ff, wr_in;
   logic [csd_pkg::QAddrW-1:0]   rd_ff, rd_in;
   logic [csd_pkg::QCountW-1:0]  cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == csd_pkg::QCountW'(csd_pkg::QDepth));
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sv/csd_back.sv
module csd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  csd_pkg::rec_type              head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    out_char,
   output logic                          last,
   output logic [1:0]                    status,
   output logic [csd_pkg::LenW-1:0]      declared_length,
   output logic                          truncated
);

   logic                     valid_ff, valid_in;
   logic                     char_done_ff, char_done_in;
   logic [7:0]               char_ff, char_in;
   logic                     last_ff, last_in;
   logic [1:0]               status_ff, status_in;
   logic [csd_pkg::LenW-1:0] len_ff, len_in;
   logic                     trunc_ff, trunc_in;
   logic                     load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in     = valid_ff;
      char_done_in = char_done_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      len_in       = len_ff;
      trunc_in     = trunc_ff;
      pop          = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (head.has_char && !char_done_ff) begin
               char_in   = head.ch;
               last_in   = 1'b0;
               status_in = csd_pkg::StatChar;
               len_in    = '0;
               trunc_in  = 1'b0;
               if (head.fin == csd_pkg::END_NONE) begin
                  pop = 1'b1;
               end else begin
                  char_done_in = 1'b1;
               end
            end else begin
               char_in      = 8'd0;
               last_in      = 1'b1;
               status_in    = (head.fin == csd_pkg::END_OK) ? csd_pkg::StatDone
                                                            : csd_pkg::StatErr;
               len_in       = head.len;
               trunc_in     = head.trunc;
               pop          = 1'b1;
               char_done_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         char_done_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         char_done_ff <= char_done_in;
      end
      char_ff   <= char_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      len_ff    <= len_in;
      trunc_ff  <= trunc_in;
   end

   assign rsp_valid       = valid_ff;
   assign out_char        = char_ff;
   assign last            = last_ff;
   assign status          = status_ff;
   assign declared_length = len_ff;
   assign truncated       = trunc_ff;

endmodule

FILE: sv/compactsize_string_deframer.sv
// Compact-size length-prefixed string deframer. Each request carries one byte
// of a serialized buffer (tlast marks the last byte available). A frame is a
// compact-size length prefix (below 253 is the length; 253, 254, 255 are
// followed by 2, 4, 8 little-endian bytes, only the low 32 bits kept) and a
// payload. The first min(length, max_size-1) payload bytes come out as
// character responses (status 0); the frame ends with one zero terminator
// (tlast, status 1, declared length, truncated flag) or, when the buffer runs
// out first, an error response (tlast, status 2) telling the consumer to drop
// the characters of that frame. A request is taken every cycle while the
// four-entry queue between parser and output stage has room; each request
// yields zero, one or two responses and the single output register sends one
// response per cycle while rsp_tready is high, so a byte ending a frame with
// a character yields two responses. max_size resets to 256; the user must
// write it on the csr channel only while the block is idle (not enforced).
module compactsize_string_deframer (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [16:0]  csr_data,    // max_size
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] in_byte
   input  logic         req_tlast,   // end_of_buffer
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // [7:0] out_char, [39:8] declared_length,
                                     // [40] truncated, [47:41] zero
   output logic         rsp_tlast,   // last
   output logic [1:0]   rsp_tuser    // status
);

   logic [csd_pkg::MaxSizeW-1:0] max_size_ff, max_size_in;
   logic                         acc;
   logic                         push;
   logic                         pop;
   logic                         q_empty;
   logic                         q_full;
   csd_pkg::rec_type             front_rec;
   csd_pkg::rec_type             head_rec;
   logic [7:0]                   out_char;
   logic [csd_pkg::LenW-1:0]     declared_length;
   logic                         truncated;

   // config register, always ready
   assign csr_ready   = 1'b1;
   assign max_size_in = (csr_valid && csr_ready) ? csr_data : max_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= csd_pkg::MaxSizeW'(256);
      end else begin
         max_size_ff <= max_size_in;
      end
   end

   // front takes a byte whenever the queue can hold its record
   assign req_tready = !q_full;
   assign acc        = req_tvalid && req_tready;

   csd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .in_byte  (req_tdata),
      .eob      (req_tlast),
      .max_size (max_size_ff),
      .push     (push),
      .rec      (front_rec)
   );

   csd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (front_rec),
      .pop      (pop),
      .head     (head_rec),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back expands each record into a char and/or an ending response
   csd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head_rec),
      .empty           (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .out_char        (out_char),
      .last            (rsp_tlast),
      .status          (rsp_tuser),
      .declared_length (declared_length),
      .truncated       (truncated)
   );

   assign rsp_tdata = {7'b0, truncated, declared_length, out_char};

   // an ending response is exactly one with a non-char status
   a_last_status : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != csd_pkg::StatChar)))
      else $error("tlast and status disagree");

   // terminator and error carry a zero character
   a_end_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (out_char == 8'd0))
      else $error("nonzero char on frame end");

   // length and truncated only on a completed frame
   a_len_only_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != csd_pkg::StatDone)
         |-> (declared_length == '0 && !truncated))
      else $error("length or truncated outside frame-complete response");

   // a full queue never lets a request in
   a_no_acc_full : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !acc)
      else $error("request accepted with queue full");

endmodule
